@@ rtl/core/ieurf_pkg.sv @@
`default_nettype none

package ieurf_pkg;

  localparam int XLEN      = 32;
  localparam int REG_COUNT = 32;
  localparam int REG_AW    = $clog2(REG_COUNT);

  typedef logic [XLEN-1:0]   word_t;
  typedef logic [REG_AW-1:0] reg_idx_t;
  typedef logic [3:0]        label_t;

  // Operation codes; 14 and 15 are undefined and produce an all-zero result.
  typedef enum logic [3:0] {
    OP_ADD  = 4'd0,
    OP_ADDI = 4'd1,
    OP_SUB  = 4'd2,
    OP_MUL  = 4'd3,
    OP_AND  = 4'd4,
    OP_ANDI = 4'd5,
    OP_OR   = 4'd6,
    OP_ORI  = 4'd7,
    OP_NOR  = 4'd8,
    OP_SLT  = 4'd9,
    OP_SLTI = 4'd10,
    OP_BEQ  = 4'd11,
    OP_BNE  = 4'd12,
    OP_J    = 4'd13
  } op_t;

  localparam logic STATUS_OK        = 1'b0;
  localparam logic STATUS_WR_ZERO   = 1'b1;

endpackage

`default_nettype wire

@@ rtl/core/integer_execute_unit_regfile.sv @@
`default_nettype none

// Integer execute unit with a 32 x 32-bit register file (register 0 reads as
// zero). One decoded instruction is taken per transfer on the input channel
// and exactly one result transfer follows on the output channel. The unit
// sustains one instruction per cycle while the output is not stalled. An
// instruction is accepted in every cycle in which the read stage is empty or
// moving on to the result register. The read stage moves on whenever the
// result register is free or being drained. Only output backpressure stalls
// the input. The path has two register stages, the read stage and the
// result register. The input transfer edge reads both register-file ports
// into registers. The edge on which the read stage moves on runs the ALU
// (including a 32x32 low-half multiply), loads the result register and
// writes the destination back. A write that retires in the same cycle as a
// dependent instruction is read is forwarded, so back-to-back dependent
// instructions see the newest value. The register file comes out of reset
// as all zeros through per-entry valid bits; no clearing pass is needed.
// Branches (beq, bne) compare dest_reg against source_reg; a target label
// at or above LABEL_COUNT is never taken. An ALU write to register 0 is
// refused with status 1.
module integer_execute_unit_regfile #(
  parameter int LABEL_COUNT = 16
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  // instruction channel
  input  wire logic                  in_valid,
  output logic                       in_ready,
  input  wire logic [3:0]            operation,
  input  wire ieurf_pkg::reg_idx_t   dest_reg,
  input  wire ieurf_pkg::reg_idx_t   source_reg,
  input  wire ieurf_pkg::reg_idx_t   second_reg,
  input  wire logic signed [15:0]    immediate,
  input  wire ieurf_pkg::label_t     target_label,
  // result channel
  output logic                       out_valid,
  input  wire logic                  out_ready,
  output logic                       status,
  output logic                       branch_taken,
  output ieurf_pkg::label_t          branch_target,
  output logic signed [31:0]         written_value
);

  import ieurf_pkg::*;

  // ---------------------------------------------------------------------------
  // Register file storage: data array plus a valid bit per entry so that reset
  // makes every register read as zero. Entry 0 is never written.
  // ---------------------------------------------------------------------------
  word_t                rf_mem [REG_COUNT];
  logic [REG_COUNT-1:0] rf_valid;

  // ---------------------------------------------------------------------------
  // Stage 1: operands read, instruction fields held
  // ---------------------------------------------------------------------------
  logic     s1_valid;
  logic [3:0] s1_op;
  reg_idx_t s1_rd;
  word_t    s1_imm;
  label_t   s1_label;

  // raw read data, valid flag and forward select for each read port
  word_t    a_raw, b_raw;
  logic     a_ok, b_ok;
  logic     a_fwd, b_fwd;
  word_t    fwd_data;

  logic     in_xfer;
  logic     s1_adv;

  // write-back from stage 1 into the file
  logic     wr_en;
  reg_idx_t wr_addr;
  word_t    wr_data;

  // read addresses; branches compare dest_reg on port B
  reg_idx_t ra_addr, rb_addr;
  logic     in_is_branch;

  assign s1_adv   = s1_valid && (!out_valid || out_ready);
  assign in_ready = !s1_valid || s1_adv;
  assign in_xfer  = in_valid && in_ready;

  assign in_is_branch = (operation == OP_BEQ) || (operation == OP_BNE);
  assign ra_addr      = source_reg;
  assign rb_addr      = in_is_branch ? dest_reg : second_reg;

  // Register file read port registers; forwarding covers a write retiring in
  // the cycle the read is taken.
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      a_raw    <= rf_mem[ra_addr];
      b_raw    <= rf_mem[rb_addr];
      a_ok     <= rf_valid[ra_addr];
      b_ok     <= rf_valid[rb_addr];
      a_fwd    <= wr_en && (wr_addr == ra_addr);
      b_fwd    <= wr_en && (wr_addr == rb_addr);
      fwd_data <= wr_data;
    end
  end

  // Register file write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      rf_mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rf_valid <= '0;
    end else if (wr_en) begin
      rf_valid[wr_addr] <= 1'b1;
    end
  end

  // Stage 1 control and payload
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_xfer) begin
      s1_valid <= 1'b1;
    end else if (s1_adv) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      s1_op    <= operation;
      s1_rd    <= dest_reg;
      s1_imm   <= word_t'(signed'(immediate));
      s1_label <= target_label;
    end
  end

  // ---------------------------------------------------------------------------
  // Execute: operand select, ALU and branch decision
  // ---------------------------------------------------------------------------
  word_t opa, opb;
  word_t alu_val;
  logic  is_alu;
  logic  cond_taken;
  logic  label_ok;

  assign opa = a_fwd ? fwd_data : (a_ok ? a_raw : '0);
  assign opb = b_fwd ? fwd_data : (b_ok ? b_raw : '0);

  assign label_ok = 32'(s1_label) < 32'(LABEL_COUNT);

  always_comb begin
    alu_val    = '0;
    is_alu     = 1'b1;
    cond_taken = 1'b0;
    unique case (op_t'(s1_op))
      OP_ADD:  alu_val = opa + opb;
      OP_ADDI: alu_val = opa + s1_imm;
      OP_SUB:  alu_val = opa - opb;
      OP_MUL:  alu_val = word_t'(opa * opb);
      OP_AND:  alu_val = opa & opb;
      OP_ANDI: alu_val = opa & s1_imm;
      OP_OR:   alu_val = opa | opb;
      OP_ORI:  alu_val = opa | s1_imm;
      OP_NOR:  alu_val = ~(opa | opb);
      OP_SLT:  alu_val = word_t'($signed(opa) < $signed(opb));
      OP_SLTI: alu_val = word_t'($signed(opa) < $signed(s1_imm));
      OP_BEQ: begin
        is_alu     = 1'b0;
        cond_taken = (opb == opa);
      end
      OP_BNE: begin
        is_alu     = 1'b0;
        cond_taken = (opb != opa);
      end
      OP_J: begin
        is_alu     = 1'b0;
        cond_taken = 1'b1;
      end
      default: begin
        is_alu = 1'b0;
      end
    endcase
  end

  assign wr_en   = s1_adv && is_alu && (s1_rd != '0);
  assign wr_addr = s1_rd;
  assign wr_data = alu_val;

  // ---------------------------------------------------------------------------
  // Result register
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_adv) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      status        <= (is_alu && s1_rd == '0) ? STATUS_WR_ZERO : STATUS_OK;
      branch_taken  <= !is_alu && cond_taken && label_ok;
      branch_target <= (!is_alu && cond_taken && label_ok) ? s1_label : '0;
      written_value <= (is_alu && s1_rd != '0) ? signed'(alu_val) : '0;
    end
  end

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  a_zero_never_written: assert property (@(posedge clk) disable iff (rst)
    !rf_valid[0])
    else $error("register 0 marked written");

  a_refused_no_value: assert property (@(posedge clk) disable iff (rst)
    (out_valid && status) |-> (written_value == '0 && !branch_taken))
    else $error("refused write carries a value or branch");

  a_taken_clean: assert property (@(posedge clk) disable iff (rst)
    (out_valid && branch_taken) |-> (status == STATUS_OK && written_value == '0))
    else $error("taken branch with ALU fields set");

  a_write_retires: assert property (@(posedge clk) disable iff (rst)
    wr_en |=> (out_valid && written_value == $past(wr_data)))
    else $error("register write not reported in result");

  a_ready_when_empty: assert property (@(posedge clk) disable iff (rst)
    !s1_valid |-> in_ready)
    else $error("input stalled with empty read stage");

endmodule

`default_nettype wire

@@ sim/tb_top.sv @@
`default_nettype none

// Block-level test for the integer execute unit.
// Instructions come from a queue filled at time zero: a directed set that hits
// the immediate extremes, every opcode, the zero-register and branch corner
// cases, and then a long random stream. The random stream draws its registers
// mostly from a small pool so that instructions depend on one another.
// A shadow register file in the bench computes each result when its
// instruction transfer happens. The monitor checks every result transfer in
// order against the oldest prediction.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import ieurf_pkg::*;

  localparam int LABEL_COUNT  = 16;
  localparam int RANDOM_ITEMS = 800;
  localparam int IDLE_LIMIT   = 2000;  // cycles with no transfer on either channel
  localparam int SETTLE_TIME  = 10;    // cycles to wait after the last result

  // Codes outside op_t; the unit must answer them with an all-zero result.
  localparam logic [3:0] OP_UNDEF_LO = 4'd14;
  localparam logic [3:0] OP_UNDEF_HI = 4'd15;

  typedef struct {
    logic [3:0]          operation;
    reg_idx_t            dest_reg;
    reg_idx_t            source_reg;
    reg_idx_t            second_reg;
    logic signed [15:0]  immediate;
    label_t              target_label;
    bit                  drain;  // hold this one back until all results are in
  } instr_t;

  typedef struct {
    logic                status;
    logic                branch_taken;
    label_t              branch_target;
    logic signed [31:0]  written_value;
  } result_t;

  // DUT connections; every input starts at a known value
  logic               clk           = 1'b0;
  logic               rst           = 1'b1;
  logic               in_valid      = 1'b0;
  logic               in_ready;
  logic [3:0]         operation     = '0;
  reg_idx_t           dest_reg      = '0;
  reg_idx_t           source_reg    = '0;
  reg_idx_t           second_reg    = '0;
  logic signed [15:0] immediate     = '0;
  label_t             target_label  = '0;
  logic               out_valid;
  logic               out_ready     = 1'b0;
  logic               status;
  logic               branch_taken;
  label_t             branch_target;
  logic signed [31:0] written_value;

  instr_t  instr_queue[$];
  result_t expected_results[$];
  word_t   shadow_regs[REG_COUNT];

  int mismatch_count  = 0;
  int result_count    = 0;
  int taken_count     = 0;
  int refused_count   = 0;
  int drain_count     = 0;
  int idle_cycles     = 0;

  integer_execute_unit_regfile #(
    .LABEL_COUNT (LABEL_COUNT)
  ) i_dut (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .operation     (operation),
    .dest_reg      (dest_reg),
    .source_reg    (source_reg),
    .second_reg    (second_reg),
    .immediate     (immediate),
    .target_label  (target_label),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .status        (status),
    .branch_taken  (branch_taken),
    .branch_target (branch_target),
    .written_value (written_value)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Shadow execute: runs one instruction on the bench's register file and
  // returns the result the unit must produce for it.
  // ---------------------------------------------------------------------------
  function automatic result_t execute_instr(instr_t ins);
    word_t   a;
    word_t   b;
    word_t   imm_ext;
    word_t   val;
    logic    is_alu;
    logic    taken;
    result_t res;
    // r0 is never written, so it keeps reading zero
    a       = shadow_regs[ins.source_reg];
    b       = shadow_regs[ins.second_reg];
    imm_ext = {{16{ins.immediate[15]}}, ins.immediate};  // andi/ori too
    val     = '0;
    is_alu  = 1'b1;
    taken   = 1'b0;
    case (op_t'(ins.operation))
      OP_ADD:  val = a + b;
      OP_ADDI: val = a + imm_ext;
      OP_SUB:  val = a - b;
      OP_MUL:  val = a * b;  // 32-bit context keeps the low half
      OP_AND:  val = a & b;
      OP_ANDI: val = a & imm_ext;
      OP_OR:   val = a | b;
      OP_ORI:  val = a | imm_ext;
      OP_NOR:  val = ~(a | b);
      OP_SLT:  val = ($signed(a) < $signed(b)) ? 32'd1 : 32'd0;
      OP_SLTI: val = ($signed(a) < $signed(imm_ext)) ? 32'd1 : 32'd0;
      // branches compare dest_reg against source_reg
      OP_BEQ: begin
        is_alu = 1'b0;
        taken  = (shadow_regs[ins.dest_reg] == a);
      end
      OP_BNE: begin
        is_alu = 1'b0;
        taken  = (shadow_regs[ins.dest_reg] != a);
      end
      OP_J: begin
        is_alu = 1'b0;
        taken  = 1'b1;
      end
      default: begin
        is_alu = 1'b0;
      end
    endcase
    res.status        = STATUS_OK;
    res.branch_taken  = 1'b0;
    res.branch_target = '0;
    res.written_value = '0;
    if (is_alu) begin
      if (ins.dest_reg == '0) begin
        res.status = STATUS_WR_ZERO;
      end else begin
        shadow_regs[ins.dest_reg] = val;
        res.written_value         = val;
      end
    end else if (taken && ins.target_label < LABEL_COUNT) begin
      res.branch_taken  = 1'b1;
      res.branch_target = ins.target_label;
    end
    return res;
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus construction
  // ---------------------------------------------------------------------------
  function automatic instr_t make_instr(logic [3:0] op, int rd, int rs, int rt, int imm,
                                        int label);
    instr_t ins;
    ins.operation    = op;
    ins.dest_reg     = reg_idx_t'(rd);
    ins.source_reg   = reg_idx_t'(rs);
    ins.second_reg   = reg_idx_t'(rt);
    ins.immediate    = 16'(imm);
    ins.target_label = label_t'(label);
    ins.drain        = 1'b0;
    return ins;
  endfunction

  // Mostly a small pool so results feed later instructions; sometimes anything.
  function automatic int pick_reg();
    return ($urandom_range(0, 3) != 0) ? int'($urandom_range(0, 7)) : int'($urandom_range(0, 31));
  endfunction

  function automatic int pick_imm();
    case ($urandom_range(0, 7))
      0:       return 32767;
      1:       return -32768;
      2:       return -1;
      3, 4:    return int'($urandom_range(0, 8)) - 4;
      default: return int'($urandom_range(0, 65535)) - 32768;
    endcase
  endfunction

  function automatic instr_t random_instr();
    logic [3:0] op;
    if ($urandom_range(0, 49) == 0) begin
      op = 4'($urandom_range(OP_UNDEF_LO, OP_UNDEF_HI));
    end else begin
      op = 4'($urandom_range(OP_ADD, OP_J));
    end
    return make_instr(op, pick_reg(), pick_reg(), pick_reg(), pick_imm(),
                      $urandom_range(0, 15));
  endfunction

  initial begin : stimulus
    instr_t ins;
    foreach (shadow_regs[i]) shadow_regs[i] = '0;

    // directed: immediate extremes, every opcode, zero-register and branch cases
    instr_queue.push_back(make_instr(OP_ADDI, 1, 0, 0, 32767, 0));
    instr_queue.push_back(make_instr(OP_ADDI, 2, 0, 0, -32768, 0));
    instr_queue.push_back(make_instr(OP_ADDI, 3, 0, 0, -1, 0));      // all ones
    instr_queue.push_back(make_instr(OP_ADD, 4, 1, 2, 0, 0));
    instr_queue.push_back(make_instr(OP_SUB, 5, 0, 3, 0, 0));
    instr_queue.push_back(make_instr(OP_SUB, 6, 2, 1, 0, 0));
    instr_queue.push_back(make_instr(OP_MUL, 7, 3, 3, 0, 0));
    instr_queue.push_back(make_instr(OP_MUL, 8, 1, 1, 0, 0));
    instr_queue.push_back(make_instr(OP_AND, 9, 3, 1, 0, 0));
    instr_queue.push_back(make_instr(OP_ANDI, 10, 3, 0, -32768, 0)); // sign-extended mask
    instr_queue.push_back(make_instr(OP_OR, 11, 1, 2, 0, 0));
    instr_queue.push_back(make_instr(OP_ORI, 12, 0, 0, -1, 0));
    instr_queue.push_back(make_instr(OP_NOR, 13, 0, 0, 0, 0));
    instr_queue.push_back(make_instr(OP_SLT, 14, 2, 1, 0, 0));
    instr_queue.push_back(make_instr(OP_SLTI, 15, 1, 0, -32768, 0));
    instr_queue.push_back(make_instr(OP_SLT, 16, 3, 0, 0, 0));       // -1 < 0
    instr_queue.push_back(make_instr(OP_BEQ, 0, 0, 0, 0, 15));       // taken
    instr_queue.push_back(make_instr(OP_BEQ, 1, 2, 0, 0, 5));        // not taken
    instr_queue.push_back(make_instr(OP_BNE, 1, 2, 0, 0, 0));        // taken
    instr_queue.push_back(make_instr(OP_BNE, 0, 0, 0, 0, 7));        // not taken
    instr_queue.push_back(make_instr(OP_J, 31, 31, 31, -1, 9));
    instr_queue.push_back(make_instr(OP_ADD, 0, 1, 1, 0, 0));        // refused write
    instr_queue.push_back(make_instr(OP_ADDI, 31, 31, 31, 1, 15));   // unwritten reg reads 0
    instr_queue.push_back(make_instr(OP_UNDEF_LO, 31, 1, 2, -1, 15));
    instr_queue.push_back(make_instr(OP_UNDEF_HI, 31, 3, 3, 32767, 15));

    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      ins = random_instr();
      // pause the sender until the unit is empty, now and then
      ins.drain = (n % 150 == 75) || ($urandom_range(0, 99) == 0);
      instr_queue.push_back(ins);
    end

    repeat (3) @(posedge clk);
    rst <= 1'b0;

    while (instr_queue.size() != 0 || in_valid) @(posedge clk);
    while (expected_results.size() != 0) @(posedge clk);
    repeat (SETTLE_TIME) @(posedge clk);

    $display("Checked %0d results: %0d taken branches/jumps, %0d refused r0 writes,",
             result_count, taken_count, refused_count);
    $display("with %0d full drains of the unit and random stalls on both sides.",
             drain_count);
    if (mismatch_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Driver: bursts of random length with random gaps. The prediction is made
  // at the edge where the instruction transfer happens, so the shadow file
  // sees instructions in the same order as the unit.
  // ---------------------------------------------------------------------------
  instr_t cur_instr;
  int     burst_left = 0;
  int     gap_left   = 0;

  always @(posedge clk) begin : drive_instr
    logic fire;
    logic present;
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      fire = in_valid && in_ready;
      if (fire) begin
        expected_results.push_back(execute_instr(cur_instr));
      end
      // valid holds with a stable payload until the transfer
      if (!in_valid || fire) begin
        present = 1'b0;
        if (gap_left > 0) begin
          gap_left--;
        end else if (instr_queue.size() != 0 &&
                     !(instr_queue[0].drain && expected_results.size() != 0)) begin
          if (instr_queue[0].drain) drain_count++;
          cur_instr = instr_queue.pop_front();
          present   = 1'b1;
          if (burst_left == 0) begin
            burst_left = $urandom_range(1, 40);
            // mostly short gaps, sometimes long ones, sometimes none
            gap_left = ($urandom_range(0, 3) == 0) ? $urandom_range(5, 20) : $urandom_range(0, 3);
          end else begin
            burst_left--;
          end
        end
        in_valid <= present;
        if (present) begin
          operation    <= cur_instr.operation;
          dest_reg     <= cur_instr.dest_reg;
          source_reg   <= cur_instr.source_reg;
          second_reg   <= cur_instr.second_reg;
          immediate    <= cur_instr.immediate;
          target_label <= cur_instr.target_label;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Result-side backpressure: a rotating 16-bit ready pattern, reloaded at
  // random intervals with always-ready, random, sparse or mostly-stalled.
  // ---------------------------------------------------------------------------
  logic [15:0] ready_pattern = '1;
  int          pattern_left  = 0;

  always @(posedge clk) begin : drive_ready
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (pattern_left == 0) begin
        case ($urandom_range(0, 4))
          0, 1:    ready_pattern = '1;
          2:       ready_pattern = 16'($urandom());
          3:       ready_pattern = 16'h1111;
          default: ready_pattern = 16'($urandom() & $urandom());
        endcase
        pattern_left = $urandom_range(32, 160);
      end else begin
        pattern_left--;
        ready_pattern = {ready_pattern[0], ready_pattern[15:1]};
      end
      out_ready <= ready_pattern[0];
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: each result transfer against the oldest prediction
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : check_result
    result_t exp_res;
    if (!rst && out_valid && out_ready) begin
      if (expected_results.size() == 0) begin
        $error("result transfer with no instruction outstanding");
        mismatch_count++;
      end else begin
        exp_res = expected_results.pop_front();
        result_count++;
        if (exp_res.branch_taken) taken_count++;
        if (exp_res.status == STATUS_WR_ZERO) refused_count++;
        if (status !== exp_res.status) begin
          $error("status: expected %0b, got %0b", exp_res.status, status);
          mismatch_count++;
        end
        if (branch_taken !== exp_res.branch_taken) begin
          $error("branch_taken: expected %0b, got %0b", exp_res.branch_taken, branch_taken);
          mismatch_count++;
        end
        if (branch_target !== exp_res.branch_target) begin
          $error("branch_target: expected %0d, got %0d", exp_res.branch_target,
                 branch_target);
          mismatch_count++;
        end
        if (written_value !== exp_res.written_value) begin
          $error("written_value: expected %h, got %h", exp_res.written_value, written_value);
          mismatch_count++;
        end
      end
    end
  end

  // Watchdog: a run that stops moving on both channels is a hang
  always @(posedge clk) begin : watchdog
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("Timeout: no transfer for %0d cycles", IDLE_LIMIT);
        $display("Verification failed");
        $finish;
      end
    end
  end

endmodule

`default_nettype wire

@@ filelist.f @@
rtl/core/ieurf_pkg.sv
rtl/core/integer_execute_unit_regfile.sv
sim/tb_top.sv
